>>> rtl/core/plba_pkg.sv
// plba_pkg: shared codes for the per-layer block allocator
// fixed port widths, table sizes, command, status, register index and sequencer state codes
// no dependencies
`default_nettype none

package plba_pkg;

  localparam int NUM_BLOCKS = 256;
  localparam int NUM_LAYERS = 64;

  localparam int LAYER_W  = 6;
  localparam int BLOCK_W  = 8;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 3;
  localparam int LCNT_W   = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW       = 3'd0,
    ST_REUSED    = 3'd1,
    ST_FREED     = 3'd2,
    ST_BAD_LAYER = 3'd3,
    ST_FULL      = 3'd4,
    ST_IGNORED   = 3'd5
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_CAP   = 2'd1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ALOOK = 7'b0000010,
    S_ANEXT = 7'b0000100,
    S_FBLK  = 7'b0001000,
    S_FLAY  = 7'b0010000,
    S_CNT   = 7'b0100000,
    S_DONE  = 7'b1000000
  } seq_state_t;

endpackage

`default_nettype wire

>>> rtl/core/plba_blk_mem.sv
// plba_blk_mem: per-block table (owner layer, queue link, free flag)
// one write port, one registered read port; entries are written before read
`default_nettype none

module plba_blk_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int LW    = 6
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [LW-1:0] rd_owner,
  output logic      [AW-1:0] rd_next,
  output logic               rd_free,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [LW-1:0] wr_owner,
  input  wire logic [AW-1:0] wr_next,
  input  wire logic          wr_free
);

  localparam int EW = LW + AW + 1;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_owner, wr_next, wr_free};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_owner = rd_data_r[EW-1 -: LW];
  assign rd_next  = rd_data_r[AW:1];
  assign rd_free  = rd_data_r[0];

endmodule

`default_nettype wire

>>> rtl/core/plba_lyr_mem.sv
// plba_lyr_mem: per-layer queue table (head, tail, nonempty, owned count)
// one write port, one registered read port; per-layer valid flops stand for reset
`default_nettype none

module plba_lyr_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int BW    = 8,
  parameter int CW    = 9
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [BW-1:0] rd_head,
  output logic      [BW-1:0] rd_tail,
  output logic               rd_nonempty,
  output logic      [CW-1:0] rd_count,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [BW-1:0] wr_head,
  input  wire logic [BW-1:0] wr_tail,
  input  wire logic          wr_nonempty,
  input  wire logic [CW-1:0] wr_count
);

  localparam int EW = 2 * BW + 1 + CW;

  logic [EW-1:0]    mem [DEPTH];
  logic [EW-1:0]    rd_data_r;
  logic [DEPTH-1:0] vld_r;
  logic             rd_vld_r;
  logic             rd_in_range;

  assign rd_in_range = 32'(rd_addr) < DEPTH;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_head, wr_tail, wr_nonempty, wr_count};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // an entry never written reads as empty with zero count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= rd_in_range && vld_r[rd_addr];
      end
    end
  end

  assign rd_head     = rd_data_r[EW-1 -: BW];
  assign rd_tail     = rd_data_r[EW-BW-1 -: BW];
  assign rd_nonempty = rd_vld_r && rd_data_r[CW];
  assign rd_count    = rd_vld_r ? rd_data_r[CW-1:0] : '0;

endmodule

`default_nettype wire

>>> rtl/core/per_layer_block_allocator_unit.sv
// per_layer_block_allocator_unit: top level, request sequencer and config registers
// uses plba_pkg, plba_blk_mem and plba_lyr_mem
`default_nettype none

// Hands out cache blocks tagged with a layer. An allocate reuses the oldest
// freed block of its layer (a linked FIFO per layer) or issues the next new
// block id up to the cap; a free queues an issued in-use block to its owner.
// One request is worked at a time by a small sequencer that reads, modifies
// and writes back a block table and a layer table, each with a single
// registered read port. The steps follow the chain of dependent table reads
// (for an allocate the layer entry, then the queue link of a reuse; for a
// free the block entry, then the owner's layer entry of a valid free, then
// the count of the requested layer) and end with a handoff to the output
// register, which lets the next request enter while a result waits. The
// layer table is tracked by per-layer valid flops, so there is no clearing
// pass after reset. Configuration is taken at any time with cfg_ready high.

module per_layer_block_allocator_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_cmd,
  input  wire logic [plba_pkg::LAYER_W-1:0]     in_layer,
  input  wire logic [plba_pkg::BLOCK_W-1:0]     in_block_id,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [plba_pkg::STATUS_W-1:0]    out_status,
  output logic      [plba_pkg::BLOCK_W-1:0]     out_granted_block,
  output logic      [plba_pkg::COUNT_W-1:0]     out_layer_blocks,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [plba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [plba_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import plba_pkg::*;

  localparam int BW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int LW = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
  localparam int CW = $clog2(NUM_BLOCKS + 1);

  // config registers
  logic [LCNT_W-1:0]     layer_count_r;
  logic [CFG_DATA_W-1:0] block_cap_r;

  // sequencer state
  seq_state_t           state_r, state_nxt;
  logic [LAYER_W-1:0]   layer_r, layer_nxt;
  logic [BLOCK_W-1:0]   bid_r, bid_nxt;
  logic                 lvalid_r, lvalid_nxt;
  logic [LW-1:0]        own_r, own_nxt;
  logic [BW-1:0]        blk_r, blk_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  status_t              status_r, status_nxt;
  logic [CW-1:0]        issued_r, issued_nxt;

  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [BLOCK_W-1:0]   out_granted_r;
  logic [COUNT_W-1:0]   out_blocks_r;

  // table ports
  logic          b_rd_en, b_wr_en, b_rd_free, b_wr_free;
  logic [BW-1:0] b_rd_addr, b_rd_next, b_wr_addr, b_wr_next;
  logic [LW-1:0] b_rd_owner, b_wr_owner;

  logic          l_rd_en, l_wr_en, l_rd_ne, l_wr_ne;
  logic [LW-1:0] l_rd_addr, l_wr_addr;
  logic [BW-1:0] l_rd_head, l_rd_tail, l_wr_head, l_wr_tail;
  logic [CW-1:0] l_rd_cnt, l_wr_cnt;

  logic          in_xfer, out_free, in_lvalid, free_ok;
  logic [CW-1:0] cap_lim;

  plba_blk_mem #(
    .DEPTH (NUM_BLOCKS),
    .AW    (BW),
    .LW    (LW)
  ) u_blk_mem (
    .clk      (clk),
    .rd_en    (b_rd_en),
    .rd_addr  (b_rd_addr),
    .rd_owner (b_rd_owner),
    .rd_next  (b_rd_next),
    .rd_free  (b_rd_free),
    .wr_en    (b_wr_en),
    .wr_addr  (b_wr_addr),
    .wr_owner (b_wr_owner),
    .wr_next  (b_wr_next),
    .wr_free  (b_wr_free)
  );

  plba_lyr_mem #(
    .DEPTH (NUM_LAYERS),
    .AW    (LW),
    .BW    (BW),
    .CW    (CW)
  ) u_lyr_mem (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_en       (l_rd_en),
    .rd_addr     (l_rd_addr),
    .rd_head     (l_rd_head),
    .rd_tail     (l_rd_tail),
    .rd_nonempty (l_rd_ne),
    .rd_count    (l_rd_cnt),
    .wr_en       (l_wr_en),
    .wr_addr     (l_wr_addr),
    .wr_head     (l_wr_head),
    .wr_tail     (l_wr_tail),
    .wr_nonempty (l_wr_ne),
    .wr_count    (l_wr_cnt)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign in_lvalid = (32'(in_layer) < 32'(layer_count_r)) && (32'(in_layer) < NUM_LAYERS);
  assign free_ok   = (32'(bid_r) < 32'(issued_r)) && !b_rd_free;

  always_comb begin
    if (block_cap_r == '0 || 32'(block_cap_r) > NUM_BLOCKS) begin
      cap_lim = CW'(NUM_BLOCKS);
    end else begin
      cap_lim = CW'(block_cap_r);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    layer_nxt  = layer_r;
    bid_nxt    = bid_r;
    lvalid_nxt = lvalid_r;
    own_nxt    = own_r;
    blk_nxt    = blk_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    issued_nxt = issued_r;

    b_rd_en    = 1'b0;
    b_rd_addr  = BW'(in_block_id);
    b_wr_en    = 1'b0;
    b_wr_addr  = blk_r;
    b_wr_owner = LW'(layer_r);
    b_wr_next  = l_rd_head;
    b_wr_free  = 1'b0;

    l_rd_en    = 1'b0;
    l_rd_addr  = LW'(in_layer);
    l_wr_en    = 1'b0;
    l_wr_addr  = LW'(layer_r);
    l_wr_head  = l_rd_head;
    l_wr_tail  = l_rd_tail;
    l_wr_ne    = l_rd_ne;
    l_wr_cnt   = l_rd_cnt;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          layer_nxt  = in_layer;
          bid_nxt    = in_block_id;
          lvalid_nxt = in_lvalid;
          blk_nxt    = '0;
          if (cmd_t'(in_cmd) == CMD_FREE) begin
            b_rd_en   = 1'b1;
            state_nxt = S_FBLK;
          end else begin
            l_rd_en   = 1'b1;
            state_nxt = S_ALOOK;
          end
        end
      end

      S_ALOOK: begin
        cnt_nxt   = l_rd_cnt;
        state_nxt = S_DONE;
        if (!lvalid_r) begin
          status_nxt = ST_BAD_LAYER;
        end else if (l_rd_ne) begin
          blk_nxt    = l_rd_head;
          status_nxt = ST_REUSED;
          if (l_rd_head == l_rd_tail) begin
            // last queued block: queue goes empty, no link to follow
            l_wr_en   = 1'b1;
            l_wr_ne   = 1'b0;
            b_wr_en   = 1'b1;
            b_wr_addr = l_rd_head;
          end else begin
            b_rd_en   = 1'b1;
            b_rd_addr = l_rd_head;
            state_nxt = S_ANEXT;
          end
        end else if (issued_r >= cap_lim) begin
          status_nxt = ST_FULL;
        end else begin
          blk_nxt    = BW'(issued_r);
          issued_nxt = issued_r + CW'(1);
          cnt_nxt    = l_rd_cnt + CW'(1);
          status_nxt = ST_NEW;
          b_wr_en    = 1'b1;
          b_wr_addr  = BW'(issued_r);
          l_wr_en    = 1'b1;
          l_wr_cnt   = l_rd_cnt + CW'(1);
        end
      end

      S_ANEXT: begin
        // layer read data still holds this layer's entry
        l_wr_en   = 1'b1;
        l_wr_head = b_rd_next;
        b_wr_en   = 1'b1;
        b_wr_addr = blk_r;
        b_wr_next = b_rd_next;
        state_nxt = S_DONE;
      end

      S_FBLK: begin
        l_rd_en = 1'b1;
        if (free_ok) begin
          own_nxt    = b_rd_owner;
          b_wr_en    = 1'b1;
          b_wr_addr  = BW'(bid_r);
          b_wr_owner = b_rd_owner;
          b_wr_next  = b_rd_next;
          b_wr_free  = 1'b1;
          l_rd_addr  = b_rd_owner;
          status_nxt = ST_FREED;
          state_nxt  = S_FLAY;
        end else begin
          l_rd_addr  = LW'(layer_r);
          status_nxt = ST_IGNORED;
          state_nxt  = S_CNT;
        end
      end

      S_FLAY: begin
        // append to owner's queue; counts do not change on free
        l_wr_en   = 1'b1;
        l_wr_addr = own_r;
        l_wr_tail = BW'(bid_r);
        l_wr_ne   = 1'b1;
        if (l_rd_ne) begin
          b_wr_en    = 1'b1;
          b_wr_addr  = l_rd_tail;
          b_wr_owner = own_r;
          b_wr_next  = BW'(bid_r);
          b_wr_free  = 1'b1;
        end else begin
          l_wr_head = BW'(bid_r);
        end
        l_rd_en   = 1'b1;
        l_rd_addr = LW'(layer_r);
        state_nxt = S_CNT;
      end

      S_CNT: begin
        cnt_nxt   = l_rd_cnt;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      issued_r      <= '0;
      layer_count_r <= '0;
      block_cap_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LAYER_COUNT: layer_count_r <= cfg_wdata[LCNT_W-1:0];
          CFG_BLOCK_CAP:   block_cap_r   <= cfg_wdata;
          default:         ;
        endcase
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    layer_r  <= layer_nxt;
    bid_r    <= bid_nxt;
    lvalid_r <= lvalid_nxt;
    own_r    <= own_nxt;
    blk_r    <= blk_nxt;
    cnt_r    <= cnt_nxt;
    status_r <= status_nxt;
    if (state_r == S_DONE && out_free) begin
      out_status_r  <= status_r;
      out_granted_r <= BLOCK_W'(blk_r);
      out_blocks_r  <= lvalid_r ? COUNT_W'(cnt_r) : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_block = out_granted_r;
  assign out_layer_blocks  = out_blocks_r;

endmodule

`default_nettype wire

>>> test/per_layer_block_allocator_unit_test.sv
// per_layer_block_allocator_unit_test: self-checking bench for the per-layer block allocator
// drives allocate/free requests and config writes, predicts every result, checks the stream
// depends on plba_pkg and per_layer_block_allocator_unit
`timescale 1ns / 100ps

module per_layer_block_allocator_unit_test;
  import plba_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS = 268;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct {
    cmd_t                 cmd;
    logic [LAYER_W-1:0]   layer;
    logic [BLOCK_W-1:0]   blk;
  } request_t;

  typedef struct packed {
    status_t              status;
    logic [BLOCK_W-1:0]   blk;
    logic [COUNT_W-1:0]   count;
  } grant_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_cmd = 1'b0;
  logic [LAYER_W-1:0]     in_layer = '0;
  logic [BLOCK_W-1:0]     in_block_id = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [STATUS_W-1:0]    out_status;
  logic [BLOCK_W-1:0]     out_granted_block;
  logic [COUNT_W-1:0]     out_layer_blocks;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  per_layer_block_allocator_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_layer          (in_layer),
    .in_block_id       (in_block_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_granted_block (out_granted_block),
    .out_layer_blocks  (out_layer_blocks),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // allocator shadow state
  logic [LAYER_W-1:0] own_layer [256] = '{default: '0};
  bit                 free_flag [256];
  logic [BLOCK_W-1:0] link      [256] = '{default: '0};
  logic [BLOCK_W-1:0] fifo_head [64] = '{default: '0};
  logic [BLOCK_W-1:0] fifo_tail [64] = '{default: '0};
  bit                 fifo_busy [64];
  logic [COUNT_W-1:0] layer_owned [64] = '{default: '0};
  int unsigned        issued_cnt = 0;
  int unsigned        cfg_layers = 0;
  int unsigned        cfg_cap = 0;

  request_t request_queue [$];
  grant_t   grant_queue [$];

  int  errors = 0;
  int  requests_sent = 0;
  int  results_seen = 0;
  int  cfg_writes = 0;
  int  status_seen [6];
  int  gap_left = 0;
  int  stall_left = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;

  function automatic bit layer_ok(logic [LAYER_W-1:0] lyr);
    return lyr < cfg_layers && lyr < 64;
  endfunction

  function automatic int unsigned cap_limit();
    return (cfg_cap == 0 || cfg_cap > 256) ? 256 : cfg_cap;
  endfunction

  function automatic grant_t allocate_or_free(request_t rq);
    grant_t g;
    int unsigned ow;
    g.status = ST_IGNORED;
    g.blk = '0;
    if (rq.cmd == CMD_ALLOC) begin
      if (!layer_ok(rq.layer)) begin
        g.status = ST_BAD_LAYER;
      end else if (fifo_busy[rq.layer]) begin
        g.blk = fifo_head[rq.layer];
        if (fifo_head[rq.layer] == fifo_tail[rq.layer]) fifo_busy[rq.layer] = 1'b0;
        else fifo_head[rq.layer] = link[g.blk];
        free_flag[g.blk] = 1'b0;
        g.status = ST_REUSED;
      end else if (issued_cnt >= cap_limit()) begin
        g.status = ST_FULL;
      end else begin
        g.blk = issued_cnt[BLOCK_W-1:0];
        own_layer[g.blk] = rq.layer;
        free_flag[g.blk] = 1'b0;
        layer_owned[rq.layer]++;
        issued_cnt++;
        g.status = ST_NEW;
      end
    end else if (rq.blk < issued_cnt && !free_flag[rq.blk]) begin
      // owner queue is used even if the owner is no longer a valid layer
      ow = own_layer[rq.blk];
      if (fifo_busy[ow]) link[fifo_tail[ow]] = rq.blk;
      else begin
        fifo_head[ow] = rq.blk;
        fifo_busy[ow] = 1'b1;
      end
      fifo_tail[ow] = rq.blk;
      free_flag[rq.blk] = 1'b1;
      g.status = ST_FREED;
    end
    g.count = layer_ok(rq.layer) ? layer_owned[rq.layer] : '0;
    return g;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin
    request_t rq;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        rq.cmd = cmd_t'(in_cmd);
        rq.layer = in_layer;
        rq.blk = in_block_id;
        grant_queue = {grant_queue, allocate_or_free(rq)};
        requests_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          rq = request_queue.pop_front();
          in_valid <= 1'b1;
          in_cmd <= rq.cmd;
          in_layer <= rq.layer;
          in_block_id <= rq.blk;
          if (!quiet && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and output stall
  always @(posedge clk) begin
    grant_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_status < 6) status_seen[out_status]++;
        if (grant_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d block %0d count %0d",
                                    out_status, out_granted_block, out_layer_blocks));
        end else begin
          want = grant_queue.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
          if (out_granted_block !== want.blk)
            report_mismatch($sformatf("granted_block got %0d want %0d",
                                      out_granted_block, want.blk));
          if (out_layer_blocks !== want.count)
            report_mismatch($sformatf("layer_blocks got %0d want %0d",
                                      out_layer_blocks, want.count));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no transfer for %0d cycles", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    if (idx == CFG_LAYER_COUNT) cfg_layers = val & 32'h7F;
    else if (idx == CFG_BLOCK_CAP) cfg_cap = val & 32'h1FF;
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic put(input cmd_t cmd, input int unsigned lyr, input int unsigned bid);
    request_t rq;
    while (request_queue.size() >= 3) @(posedge clk);
    rq.cmd = cmd;
    rq.layer = lyr[LAYER_W-1:0];
    rq.blk = bid[BLOCK_W-1:0];
    request_queue = {request_queue, rq};
  endtask

  // wait until every request is out and answered, then let the sequencer settle
  // checked on the falling edge so the driver's updates of the rising edge are seen
  task automatic drain();
    @(negedge clk);
    while (request_queue.size() != 0 || in_valid || grant_queue.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_random();
    int unsigned r;
    int unsigned top;
    int unsigned lyr;
    r = $urandom_range(0, 99);
    lyr = (cfg_layers > 0 && $urandom_range(0, 3) != 0)
          ? $urandom_range(0, (cfg_layers > 64 ? 64 : cfg_layers) - 1)
          : $urandom_range(0, 63);
    top = (issued_cnt + 1 > 255) ? 255 : issued_cnt + 1;
    if (r < 45) put(CMD_ALLOC, lyr, $urandom_range(0, 255));
    else if (r < 85) put(CMD_FREE, lyr, $urandom_range(0, top));
    else put(cmd_t'($urandom_range(0, 1)), $urandom_range(0, 63), $urandom_range(0, 255));
  endtask

  initial begin
    int unsigned phase_layers [7];
    int unsigned phase_caps [7];
    phase_layers = '{8, 1, 64, 33, 64, 0, 17};
    phase_caps = '{20, 60, 100, 5, 256, 0, 0};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // no valid layer right after reset
    put(CMD_ALLOC, 0, 0);
    put(CMD_FREE, 0, 0);
    drain();

    // spare indexes must be ignored
    write_reg(CFG_SPARE_LO, 9'h1FF);
    write_reg(CFG_SPARE_HI, 0);
    write_reg(CFG_LAYER_COUNT, 4);
    write_reg(CFG_BLOCK_CAP, 3);
    put(CMD_ALLOC, 0, 0);
    put(CMD_ALLOC, 3, 0);
    put(CMD_ALLOC, 4, 0);
    put(CMD_ALLOC, 63, 255);
    put(CMD_ALLOC, 1, 0);
    put(CMD_ALLOC, 1, 0);       // cap reached
    put(CMD_FREE, 0, 0);
    put(CMD_FREE, 0, 0);        // already free
    put(CMD_FREE, 63, 255);     // never issued
    put(CMD_FREE, 3, 2);
    put(CMD_ALLOC, 2, 0);
    put(CMD_ALLOC, 0, 0);       // reuse oldest of layer 0
    put(CMD_ALLOC, 1, 0);
    put(CMD_FREE, 0, 1);
    drain();

    // owner layer shrinks out of range but the free still queues the block
    write_reg(CFG_LAYER_COUNT, 1);
    put(CMD_FREE, 3, 0);
    put(CMD_FREE, 1, 2);
    put(CMD_FREE, 0, 1);
    drain();
    write_reg(CFG_LAYER_COUNT, 64);
    put(CMD_ALLOC, 1, 0);
    put(CMD_ALLOC, 3, 0);
    drain();

    for (int p = 0; p < 7; p++) begin
      if (p == 6) quiet = 1'b1;
      write_reg(CFG_LAYER_COUNT, phase_layers[p]);
      write_reg(CFG_BLOCK_CAP, phase_caps[p]);
      repeat (PHASE_ITEMS) put_random();
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (grant_queue.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", grant_queue.size()));
    $display("covered %0d requests, %0d results, %0d register writes, %0d blocks issued",
             requests_sent, results_seen, cfg_writes, issued_cnt);
    $display("status mix: new %0d reused %0d freed %0d bad layer %0d full %0d ignored %0d",
             status_seen[0], status_seen[1], status_seen[2],
             status_seen[3], status_seen[4], status_seen[5]);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
